@@ hdl/m3i_pkg.sv @@
package m3i_pkg;

    // Field and datapath widths.
    localparam int ELEM_W   = 32;
    localparam int COF_W    = 64;
    localparam int DET_W    = 98;
    localparam int MAG_W    = 97;
    localparam int REM_W    = 98;
    localparam int N_ELEM   = 9;
    localparam int QUO_W    = 32;

    // Reset value of the singular threshold, units of 2^-48.
    localparam logic [31:0] DET_LIMIT_RESET = 32'd281474977;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [COF_W-1:0]  t_cof;

    // State carried through the restoring division pipeline.
    typedef struct packed {
        logic                              valid;
        logic                              singular;
        logic [N_ELEM-1:0]                 ovf;
        logic [N_ELEM-1:0]                 neg;
        logic [MAG_W-1:0]                  dmag;
        logic [N_ELEM-1:0][REM_W-1:0]      rem;
        logic [N_ELEM-1:0][QUO_W-1:0]      quo;
    } t_div;

endpackage

@@ hdl/m3i_cofactor.sv @@
module m3i_cofactor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_ce,
    input  logic                                i_valid,
    input  m3i_pkg::t_elem [m3i_pkg::N_ELEM-1:0] i_m,
    output logic                                o_valid,
    output m3i_pkg::t_elem [2:0]                o_row0,
    output m3i_pkg::t_cof  [m3i_pkg::N_ELEM-1:0] o_cof
);

    // Cofactor k is m[A]*m[B] - m[C]*m[D].
    localparam logic [3:0] COF_A [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] COF_B [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] COF_C [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] COF_D [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    logic signed [m3i_pkg::COF_W-1:0] r_pa [m3i_pkg::N_ELEM];
    logic signed [m3i_pkg::COF_W-1:0] r_pb [m3i_pkg::N_ELEM];
    m3i_pkg::t_elem [2:0]             r_row_a;
    m3i_pkg::t_elem [2:0]             r_row_b;
    m3i_pkg::t_cof [m3i_pkg::N_ELEM-1:0] r_cof;
    logic                             r_va;
    logic                             r_vb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_ce) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
        if (i_ce) begin
            // Product stage followed by difference stage.
            for (int k = 0; k < m3i_pkg::N_ELEM; k++) begin
                r_pa[k]  <= $signed(i_m[COF_A[k]]) * $signed(i_m[COF_B[k]]);
                r_pb[k]  <= $signed(i_m[COF_C[k]]) * $signed(i_m[COF_D[k]]);
                r_cof[k] <= r_pa[k] - r_pb[k];
            end
            r_row_a <= i_m[2:0];
            r_row_b <= r_row_a;
        end
    end

    assign o_valid = r_vb;
    assign o_row0  = r_row_b;
    assign o_cof   = r_cof;

endmodule

@@ hdl/m3i_det.sv @@
module m3i_det (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_ce,
    input  logic [31:0]                          i_det_limit,
    input  logic                                 i_valid,
    input  m3i_pkg::t_elem [2:0]                 i_row0,
    input  m3i_pkg::t_cof  [m3i_pkg::N_ELEM-1:0] i_cof,
    output m3i_pkg::t_div                        o_d
);

    localparam int DW = m3i_pkg::DET_W;
    localparam int NE = m3i_pkg::N_ELEM;

    logic [3:0]                       r_v;
    logic signed [64:0]               r_lo [3];
    logic signed [63:0]               r_hi [3];
    logic signed [DW-1:0]             r_term [3];
    logic signed [DW-1:0]             r_det;
    logic [m3i_pkg::MAG_W-1:0]        r_dmag;
    logic [NE-1:0]                    r_neg;
    logic [NE-1:0][63:0]              r_cm;
    m3i_pkg::t_cof [NE-1:0]           r_cof_p;
    m3i_pkg::t_cof [NE-1:0]           r_cof_t;
    m3i_pkg::t_cof [NE-1:0]           r_cof_s;
    m3i_pkg::t_div                    r_d;
    logic signed [DW-1:0]             n_det_neg;

    assign n_det_neg = -r_det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_d.valid <= 1'b0;
        end else if (i_ce) begin
            r_v       <= {r_v[2:0], i_valid};
            r_d.valid <= r_v[3];
        end
        if (i_ce) begin
            // Row 0 times its cofactors, each split into two 32x32 partial products.
            for (int j = 0; j < 3; j++) begin
                r_lo[j]   <= $signed(i_row0[j]) * $signed({1'b0, i_cof[3*j][31:0]});
                r_hi[j]   <= $signed(i_row0[j]) * $signed(i_cof[3*j][63:32]);
                r_term[j] <= (DW'(r_hi[j]) <<< 32) + DW'(r_lo[j]);
            end
            // Sum, magnitudes and the singular and overflow checks.
            for (int k = 0; k < NE; k++) begin
                r_cm[k]  <= r_cof_s[k][63] ? 64'(-r_cof_s[k]) : 64'(r_cof_s[k]);
                r_neg[k] <= r_cof_s[k][63] ^ r_det[DW-1];
                r_d.ovf[k] <= {33'd0, r_cm[k]} >= r_dmag;
                r_d.rem[k] <= {34'd0, r_cm[k]};
                r_d.quo[k] <= '0;
            end
            r_cof_p    <= i_cof;
            r_cof_t    <= r_cof_p;
            r_cof_s    <= r_cof_t;
            r_det      <= r_term[0] + r_term[1] + r_term[2];
            r_dmag     <= r_det[DW-1] ? n_det_neg[m3i_pkg::MAG_W-1:0]
                                      : r_det[m3i_pkg::MAG_W-1:0];
            r_d.neg      <= r_neg;
            r_d.dmag     <= r_dmag;
            r_d.singular <= (r_dmag < {65'd0, i_det_limit}) || (r_dmag == '0);
        end
    end

    assign o_d = r_d;

endmodule

@@ hdl/m3i_div_step.sv @@
module m3i_div_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  m3i_pkg::t_div i_d,
    output m3i_pkg::t_div o_d
);

    localparam int RW = m3i_pkg::REM_W;

    m3i_pkg::t_div r_d;
    m3i_pkg::t_div n_d;

    // One quotient bit per lane: shift the remainder and try a subtract.
    always_comb begin
        logic [RW-1:0] shifted;
        logic [RW-1:0] divisor;
        logic          fits;
        n_d = i_d;
        divisor = {1'b0, i_d.dmag};
        for (int k = 0; k < m3i_pkg::N_ELEM; k++) begin
            shifted = {i_d.rem[k][RW-2:0], 1'b0};
            fits = shifted >= divisor;
            n_d.rem[k] = fits ? shifted - divisor : shifted;
            n_d.quo[k] = {i_d.quo[k][m3i_pkg::QUO_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_ce) begin
            r_d.valid <= n_d.valid;
        end
        if (i_ce) begin
            r_d.singular <= n_d.singular;
            r_d.ovf      <= n_d.ovf;
            r_d.neg      <= n_d.neg;
            r_d.dmag     <= n_d.dmag;
            r_d.rem      <= n_d.rem;
            r_d.quo      <= n_d.quo;
        end
    end

    assign o_d = r_d;

endmodule

@@ hdl/matrix3_inverse_core.sv @@
// 3x3 matrix inverse, signed Q16.16 in and out.
// Input channel: i_in_valid / o_in_ready carry one row-major matrix per
// request. Output channel: o_out_valid / i_out_ready carry the nine inverse
// elements plus the invertible and saturated flags.
// From an accepted request to its result, data passes the cofactor stages, the
// determinant and check stages, the restoring division (one quotient bit per
// stage, nine lanes), and the output register.
// Throughput is one matrix per cycle while the receiver does not stall; every stage is registered.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_ready drops; nothing is dropped or duplicated. A stage that holds
// a bubble does not advance past a stalled output.
// i_cfg_we writes i_cfg_wdata into the singular threshold (units of 2^-48);
// write it only while the pipeline is empty.
// Synchronous active-low reset empties the pipeline and restores the
// threshold to its default of about 1e-6.
module matrix3_inverse_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic signed [31:0] i_in_r0c0,
    input  logic signed [31:0] i_in_r0c1,
    input  logic signed [31:0] i_in_r0c2,
    input  logic signed [31:0] i_in_r1c0,
    input  logic signed [31:0] i_in_r1c1,
    input  logic signed [31:0] i_in_r1c2,
    input  logic signed [31:0] i_in_r2c0,
    input  logic signed [31:0] i_in_r2c1,
    input  logic signed [31:0] i_in_r2c2,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_inv_r0c0,
    output logic signed [31:0] o_inv_r0c1,
    output logic signed [31:0] o_inv_r0c2,
    output logic signed [31:0] o_inv_r1c0,
    output logic signed [31:0] o_inv_r1c1,
    output logic signed [31:0] o_inv_r1c2,
    output logic signed [31:0] o_inv_r2c0,
    output logic signed [31:0] o_inv_r2c1,
    output logic signed [31:0] o_inv_r2c2,
    output logic        o_invertible,
    output logic        o_saturated
);

    localparam int NE    = m3i_pkg::N_ELEM;
    localparam int STEPS = m3i_pkg::QUO_W;

    logic [31:0]                         r_limit;
    logic                                ce;
    m3i_pkg::t_elem [NE-1:0]             in_m;
    logic                                cof_valid;
    m3i_pkg::t_elem [2:0]                cof_row0;
    m3i_pkg::t_cof  [NE-1:0]             cof_val;
    m3i_pkg::t_div                       div_d [STEPS+1];
    logic                                r_out_valid;
    logic [NE-1:0][31:0]                 r_inv;
    logic                                r_invertible;
    logic                                r_saturated;
    logic [NE-1:0][31:0]                 n_inv;
    logic [NE-1:0]                       n_sat;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= m3i_pkg::DET_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // The whole pipeline advances unless a result waits on a stalled receiver.
    assign ce         = !r_out_valid || i_out_ready;
    assign o_in_ready = ce;

    assign in_m = {i_in_r2c2, i_in_r2c1, i_in_r2c0, i_in_r1c2, i_in_r1c1,
                   i_in_r1c0, i_in_r0c2, i_in_r0c1, i_in_r0c0};

    m3i_cofactor u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (i_in_valid),
        .i_m     (in_m),
        .o_valid (cof_valid),
        .o_row0  (cof_row0),
        .o_cof   (cof_val)
    );

    m3i_det u_det (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ce        (ce),
        .i_det_limit (r_limit),
        .i_valid     (cof_valid),
        .i_row0      (cof_row0),
        .i_cof       (cof_val),
        .o_d         (div_d[0])
    );

    for (genvar g = 0; g < STEPS; g++) begin : g_div
        m3i_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_d     (div_d[g]),
            .o_d     (div_d[g+1])
        );
    end

    // Sign, saturation and singular zeroing.
    always_comb begin
        logic [31:0] q;
        for (int k = 0; k < NE; k++) begin
            q = div_d[STEPS].quo[k];
            if (div_d[STEPS].neg[k]) begin
                n_sat[k] = div_d[STEPS].ovf[k] || (q > 32'h8000_0000);
                n_inv[k] = n_sat[k] ? 32'h8000_0000 : (32'd0 - q);
            end else begin
                n_sat[k] = div_d[STEPS].ovf[k] || q[31];
                n_inv[k] = n_sat[k] ? 32'h7FFF_FFFF : q;
            end
            if (div_d[STEPS].singular) begin
                n_sat[k] = 1'b0;
                n_inv[k] = '0;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r_out_valid <= div_d[STEPS].valid;
        end
        if (ce) begin
            r_inv        <= n_inv;
            r_invertible <= !div_d[STEPS].singular;
            r_saturated  <= |n_sat;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_inv_r0c0   = r_inv[0];
    assign o_inv_r0c1   = r_inv[1];
    assign o_inv_r0c2   = r_inv[2];
    assign o_inv_r1c0   = r_inv[3];
    assign o_inv_r1c1   = r_inv[4];
    assign o_inv_r1c2   = r_inv[5];
    assign o_inv_r2c0   = r_inv[6];
    assign o_inv_r2c1   = r_inv[7];
    assign o_inv_r2c2   = r_inv[8];
    assign o_invertible = r_invertible;
    assign o_saturated  = r_saturated;

endmodule

@@ sim/tb_matrix3_inverse_core.sv @@
module tb_matrix3_inverse_core;

    // One inverse result as the block presents it.
    typedef struct packed {
        logic [8:0][31:0] elem;
        logic             invertible;
        logic             saturated;
    } t_inverse;

    // One directed stimulus row; chk set when the result is typed in.
    typedef struct {
        logic [8:0][31:0] m;
        bit               chk;
        t_inverse         res;
    } t_row;

    localparam int LATENCY  = 40;
    localparam int N_RANDOM = 1750;
    localparam longint LIMIT = 400000;

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid, o_in_ready;
    logic [8:0][31:0] in_mat;
    logic        o_out_valid, i_out_ready;
    logic signed [31:0] o_inv [9];
    logic        o_invertible, o_saturated;

    logic [31:0] thresh;
    t_inverse    inverse_q[$];
    int          errors;
    longint      cycle;
    bit          out_quiet;

    matrix3_inverse_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_in_r0c0(in_mat[0]), .i_in_r0c1(in_mat[1]), .i_in_r0c2(in_mat[2]),
        .i_in_r1c0(in_mat[3]), .i_in_r1c1(in_mat[4]), .i_in_r1c2(in_mat[5]),
        .i_in_r2c0(in_mat[6]), .i_in_r2c1(in_mat[7]), .i_in_r2c2(in_mat[8]),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_inv_r0c0(o_inv[0]), .o_inv_r0c1(o_inv[1]), .o_inv_r0c2(o_inv[2]),
        .o_inv_r1c0(o_inv[3]), .o_inv_r1c1(o_inv[4]), .o_inv_r1c2(o_inv[5]),
        .o_inv_r2c0(o_inv[6]), .o_inv_r2c1(o_inv[7]), .o_inv_r2c2(o_inv[8]),
        .o_invertible(o_invertible), .o_saturated(o_saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Inverse by adjugate over determinant, with truncation and clamping.
    function automatic t_inverse invert_matrix(logic [8:0][31:0] a, logic [31:0] lim);
        longint m [9];
        longint cof [9];
        logic signed [127:0] det;
        logic [127:0] dmag, num, q;
        logic [63:0] cm;
        bit neg;
        t_inverse r;
        for (int i = 0; i < 9; i++) m[i] = longint'($signed(a[i]));
        cof[0] = m[4]*m[8] - m[5]*m[7];
        cof[1] = m[2]*m[7] - m[1]*m[8];
        cof[2] = m[1]*m[5] - m[2]*m[4];
        cof[3] = m[5]*m[6] - m[3]*m[8];
        cof[4] = m[0]*m[8] - m[2]*m[6];
        cof[5] = m[2]*m[3] - m[0]*m[5];
        cof[6] = m[3]*m[7] - m[4]*m[6];
        cof[7] = m[1]*m[6] - m[0]*m[7];
        cof[8] = m[0]*m[4] - m[1]*m[3];
        det = 128'(signed'(m[0])) * 128'(signed'(cof[0]))
            + 128'(signed'(m[1])) * 128'(signed'(cof[3]))
            + 128'(signed'(m[2])) * 128'(signed'(cof[6]));
        dmag = det < 0 ? -det : det;
        r = '0;
        if (dmag == 0 || dmag < {96'd0, lim}) return r;
        for (int i = 0; i < 9; i++) begin
            cm  = cof[i] < 0 ? -cof[i] : cof[i];
            neg = (cof[i] < 0) != (det < 0);
            num = {32'd0, cm, 32'd0};
            q   = num / dmag;
            if (neg) begin
                if (q > 128'h8000_0000) begin
                    r.elem[i] = 32'h8000_0000; r.saturated = 1'b1;
                end else r.elem[i] = -q[31:0];
            end else begin
                if (q > 128'h7fff_ffff) begin
                    r.elem[i] = 32'h7fff_ffff; r.saturated = 1'b1;
                end else r.elem[i] = q[31:0];
            end
        end
        r.invertible = 1'b1;
        return r;
    endfunction

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'(signed'($urandom_range(0, 8)) - 4) <<< 16;
            2: return 32'(signed'($urandom_range(0, 2000)) - 1000);
            3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic logic [8:0][31:0] diag(logic [31:0] v);
        logic [8:0][31:0] d;
        d = '0;
        d[0] = v; d[4] = v; d[8] = v;
        return d;
    endfunction

    function automatic t_row row_of(logic [8:0][31:0] m, bit chk, t_inverse res);
        t_row r;
        r.m = m; r.chk = chk; r.res = res;
        return r;
    endfunction

    // Drive one request and hold it until accepted; valid drops only while idling.
    task automatic send_matrix(logic [8:0][31:0] m, t_inverse res);
        while ($urandom_range(0, 99) < 15 && !out_quiet) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        in_mat     <= m;
        inverse_q.push_back(res);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_and_write(logic [31:0] v);
        i_in_valid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        thresh       = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Receiver: random stalls, compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_inverse exp_r, got;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= out_quiet || ($urandom_range(0, 99) >= 15);
            if (o_out_valid && i_out_ready) begin
                for (int i = 0; i < 9; i++) got.elem[i] = o_inv[i];
                got.invertible = o_invertible;
                got.saturated  = o_saturated;
                if (inverse_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    exp_r = inverse_q.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got.elem[i] !== exp_r.elem[i]) begin
                            $display("%0t: element %0d expected %h actual %h",
                                     $time, i, exp_r.elem[i], got.elem[i]);
                            errors++;
                        end
                    if (got.invertible !== exp_r.invertible) begin
                        $display("%0t: invertible expected %b actual %b",
                                 $time, exp_r.invertible, got.invertible);
                        errors++;
                    end
                    if (got.saturated !== exp_r.saturated) begin
                        $display("%0t: saturated expected %b actual %b",
                                 $time, exp_r.saturated, got.saturated);
                        errors++;
                    end
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        cycle++;
        if (cycle > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_row     rows[$];
        t_inverse zero_r, one_r, sat_r;
        logic [8:0][31:0] m;
        logic [31:0] lims [4];
        errors = 0; cycle = 0; out_quiet = 1'b0;
        thresh = m3i_pkg::DET_LIMIT_RESET;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0;
        i_in_valid = 1'b0; in_mat = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Known answers: singular gives all zero, identity inverts to itself.
        zero_r = '0;
        one_r = '0;
        one_r.elem = diag(32'h0001_0000); one_r.invertible = 1'b1;
        // A one-LSB corner on an otherwise unit diagonal clamps to the maximum.
        sat_r = '0;
        sat_r.elem = diag(32'h0001_0000); sat_r.elem[0] = 32'h7fff_ffff;
        sat_r.invertible = 1'b1; sat_r.saturated = 1'b1;
        rows.push_back(row_of('0, 1, zero_r));
        rows.push_back(row_of(diag(32'h0001_0000), 1, one_r));
        rows.push_back(row_of(diag(32'h0000_0001), 1, zero_r));
        m = diag(32'h0001_0000); m[0] = 32'h0000_0001;
        rows.push_back(row_of(m, 1, sat_r));
        rows.push_back(row_of(diag(32'h0002_0000), 0, zero_r));
        rows.push_back(row_of(diag(32'hffff_0000), 0, zero_r));
        rows.push_back(row_of(diag(32'hfffff_f00), 0, zero_r));
        rows.push_back(row_of(diag(32'h7fff_ffff), 0, zero_r));
        rows.push_back(row_of(diag(32'h8000_0000), 0, zero_r));
        rows.push_back(row_of({9{32'h8000_0000}}, 1, zero_r));
        rows.push_back(row_of({9{32'hffff_ffff}}, 1, zero_r));
        m = diag(32'h0000_0100); m[1] = 32'h8000_0000;
        rows.push_back(row_of(m, 0, zero_r));
        m = '{32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h8000_0000, 32'h7fff_ffff,
              32'hffff_ffff, 32'h0, 32'h1234_5678, 32'h8000_0000};
        rows.push_back(row_of(m, 0, zero_r));
        foreach (rows[k])
            send_matrix(rows[k].m, rows[k].chk ? rows[k].res
                                              : invert_matrix(rows[k].m, thresh));

        // Threshold phases, extremes included; zero limit still flags det zero.
        lims = '{32'd0, 32'hffff_ffff, 32'd1000, m3i_pkg::DET_LIMIT_RESET};
        for (int p = 0; p < 4; p++) begin
            drain_and_write(lims[p]);
            send_matrix('0, zero_r);
            send_matrix(diag(32'h0000_0001),
                        lims[p] <= 1 ? invert_matrix(diag(32'h1), thresh) : zero_r);
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                for (int i = 0; i < 9; i++) m[i] = rand_elem();
                // Sometimes make a row a copy so the determinant is zero.
                if ($urandom_range(0, 9) == 0) m[8:6] = m[2:0];
                out_quiet = (n >= 150 && n < 250);
                send_matrix(m, invert_matrix(m, thresh));
            end
            out_quiet = 1'b0;
        end

        i_in_valid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
